/* rtl/wsp_pkg.sv */
// Shared types, codes and header constants for the WebAssembly section parser.
package wsp_pkg;

    typedef enum logic [2:0] {
        KIND_MAGIC    = 3'd0,
        KIND_VERSION  = 3'd1,
        KIND_ID       = 3'd2,
        KIND_SIZE     = 3'd3,
        KIND_NAMELEN  = 3'd4,
        KIND_NAME     = 3'd5,
        KIND_CUSTOM   = 3'd6,
        KIND_OTHER    = 3'd7
    } wsp_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_MAGIC     = 3'd1,
        ERR_VERSION   = 3'd2,
        ERR_OVERLONG  = 3'd3,
        ERR_TRUNCATED = 3'd4,
        ERR_NAME      = 3'd5
    } wsp_err_t;

    // front-end classification of a byte against the file header
    typedef struct packed {
        logic hdr_match;
        logic hdr_final;
    } wsp_class_t;

    localparam int QUEUE_DEPTH = 2;
    localparam int HEADER_BYTES = 8;
    localparam logic [2:0] LEB_LAST_INDEX = 3'd4;
    localparam logic [7:0] CUSTOM_SECTION_ID = 8'h00;

    function automatic logic [7:0] wsp_header_byte(input logic [2:0] pos);
        logic [7:0] val;
        case (pos)
            3'd0:    val = 8'h00;
            3'd1:    val = 8'h61;
            3'd2:    val = 8'h73;
            3'd3:    val = 8'h6D;
            3'd4:    val = 8'h01;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

/* rtl/wsp_in_if.sv */
// Input byte channel: one file byte and its end-of-file mark per transaction.
interface wsp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       file_last;

    modport source (output valid, output data_byte, output file_last, input ready);
    modport sink   (input valid, input data_byte, input file_last, output ready);
endinterface

/* rtl/wsp_out_if.sv */
// Result channel: one byte classification per transaction.
interface wsp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_kind;
    logic [7:0]  byte_echo;
    logic [31:0] file_offset;
    logic [15:0] section_number;
    logic [7:0]  section_kind;
    logic [31:0] decoded_value;
    logic        value_done;
    logic        section_last;
    logic [2:0]  error_code;
    logic        end_echo;

    modport source (
        output valid, output byte_kind, output byte_echo, output file_offset,
        output section_number, output section_kind, output decoded_value,
        output value_done, output section_last, output error_code, output end_echo,
        input ready
    );
    modport sink (
        input valid, input byte_kind, input byte_echo, input file_offset,
        input section_number, input section_kind, input decoded_value,
        input value_done, input section_last, input error_code, input end_echo,
        output ready
    );
endinterface

/* rtl/wasm_section_parser.sv */
// Top level of the WebAssembly section parser: front end, queue and back end.
// Takes one file byte per transaction and returns one classification per byte, in
// order. Sustained rate is one byte per clock while the result sink keeps ready high:
// every byte's parse-state update (LEB shift-accumulate, section and name down-counters,
// sticky error) is done combinationally in the back end and registered on the pop.
// Result valid rises once the input transaction has passed the queue write, then the
// result register; a two-entry queue between the front end and the back end, plus the
// result register, lets input keep flowing while a result waits to be taken.
module wasm_section_parser
    import wsp_pkg::*;
#(
    parameter int OFFSET_WIDTH        = 32,
    parameter int SECTION_COUNT_WIDTH = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    wsp_in_if.sink    bytes,
    wsp_out_if.source results
);

    localparam int CLW = $bits(wsp_class_t);
    localparam int QW  = OFFSET_WIDTH + 8 + 1 + CLW;

    logic                    push;
    logic [OFFSET_WIDTH-1:0] push_offset;
    logic [7:0]              push_byte;
    logic                    push_last;
    wsp_class_t              push_class;
    logic                    q_full;
    logic                    q_valid;
    logic                    q_pop;
    logic [QW-1:0]           q_data;
    logic [OFFSET_WIDTH-1:0] q_offset;
    logic [7:0]              q_byte;
    logic                    q_last;
    wsp_class_t              q_class;

    wsp_front #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .bytes       (bytes),
        .q_full      (q_full),
        .push        (push),
        .push_offset (push_offset),
        .push_byte   (push_byte),
        .push_last   (push_last),
        .push_class  (push_class)
    );

    wsp_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_offset, push_byte, push_last, push_class}),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_data)
    );

    assign {q_offset, q_byte, q_last, q_class} = q_data;

    wsp_back #(
        .OFFSET_WIDTH        (OFFSET_WIDTH),
        .SECTION_COUNT_WIDTH (SECTION_COUNT_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_offset (q_offset),
        .q_byte   (q_byte),
        .q_last   (q_last),
        .q_class  (q_class),
        .q_pop    (q_pop),
        .results  (results)
    );

endmodule

/* rtl/wsp_front.sv */
// Front end: accepts bytes, tracks the file offset and checks header bytes.
module wsp_front
    import wsp_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    wsp_in_if.sink                  bytes,
    input  logic                    q_full,
    output logic                    push,
    output logic [OFFSET_WIDTH-1:0] push_offset,
    output logic [7:0]              push_byte,
    output logic                    push_last,
    output wsp_class_t              push_class
);

    logic [OFFSET_WIDTH-1:0] offset_reg;
    logic [OFFSET_WIDTH-1:0] offset_next;
    logic                    in_header;

    assign bytes.ready = !q_full;
    assign push        = bytes.valid && !q_full;

    assign in_header = (offset_reg[OFFSET_WIDTH-1:3] == '0);

    assign push_offset          = offset_reg;
    assign push_byte            = bytes.data_byte;
    assign push_last            = bytes.file_last;
    assign push_class.hdr_match = in_header
                                  && (bytes.data_byte == wsp_header_byte(offset_reg[2:0]));
    assign push_class.hdr_final = in_header && (offset_reg[1:0] == 2'b11);

    always_comb
    begin
        offset_next = offset_reg;
        if (push)
        begin
            if (bytes.file_last)
                offset_next = '0;
            else
                offset_next = offset_reg + {{(OFFSET_WIDTH-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= '0;
        else
            offset_reg <= offset_next;
    end

endmodule

/* rtl/wsp_queue.sv */
// Small FIFO between the front end and the parse back end.
module wsp_queue
    import wsp_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == DEPTH_C);
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* rtl/wsp_back.sv */
// Back end: section walk, LEB128 decoding, sticky errors and the result register.
module wsp_back
    import wsp_pkg::*;
#(
    parameter int OFFSET_WIDTH        = 32,
    parameter int SECTION_COUNT_WIDTH = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    q_valid,
    input  logic [OFFSET_WIDTH-1:0] q_offset,
    input  logic [7:0]              q_byte,
    input  logic                    q_last,
    input  wsp_class_t              q_class,
    output logic                    q_pop,
    wsp_out_if.source               results
);

    typedef enum logic [7:0] {
        PH_MAGIC   = 8'b0000_0001,
        PH_VERSION = 8'b0000_0010,
        PH_ID      = 8'b0000_0100,
        PH_SIZE    = 8'b0000_1000,
        PH_NAMELEN = 8'b0001_0000,
        PH_NAME    = 8'b0010_0000,
        PH_CONTENT = 8'b0100_0000,
        PH_HALT    = 8'b1000_0000
    } wsp_phase_t;

    localparam int SCW = SECTION_COUNT_WIDTH;

    wsp_phase_t         phase_reg, phase_next;
    logic [31:0]        acc_reg, acc_next;
    logic [2:0]         lcnt_reg, lcnt_next;
    logic [31:0]        sec_left_reg, sec_left_next;
    logic [31:0]        name_left_reg, name_left_next;
    logic [SCW-1:0]     sec_cnt_reg, sec_cnt_next;
    logic [7:0]         sec_id_reg, sec_id_next;
    wsp_err_t           err_reg, err_next;

    logic               out_valid_reg, out_valid_next;
    wsp_kind_t          out_kind_reg;
    logic [7:0]         out_byte_reg;
    logic [31:0]        out_offset_reg;
    logic [15:0]        out_secnum_reg;
    logic [7:0]         out_secid_reg;
    logic [31:0]        out_value_reg;
    logic               out_done_reg;
    logic               out_seclast_reg;
    wsp_err_t           out_err_reg;
    logic               out_last_reg;

    wsp_kind_t          kind;
    logic [31:0]        value;
    logic               done;
    logic               sec_last;
    logic               leb_over;
    logic               leb_fin;
    logic [31:0]        leb_acc;
    logic [31:0]        sec_left_dec;
    logic [31:0]        name_left_dec;
    logic [31:0]        off32;
    logic [15:0]        secnum16;

    assign q_pop = q_valid && (!out_valid_reg || results.ready);

    generate
        if (OFFSET_WIDTH >= 32)
        begin : g_off_trunc
            assign off32 = q_offset[31:0];
        end
        else
        begin : g_off_ext
            assign off32 = {{(32-OFFSET_WIDTH){1'b0}}, q_offset};
        end
        if (SCW >= 16)
        begin : g_cnt_trunc
            assign secnum16 = sec_cnt_next[15:0];
        end
        else
        begin : g_cnt_ext
            assign secnum16 = {{(16-SCW){1'b0}}, sec_cnt_next};
        end
    endgenerate

    assign sec_left_dec  = sec_left_reg - 32'd1;
    assign name_left_dec = name_left_reg - 32'd1;

    // LEB128 byte step
    always_comb
    begin
        leb_over = (lcnt_reg >= LEB_LAST_INDEX) && (q_byte[7] || (q_byte[6:4] != 3'b000));
        leb_fin  = (lcnt_reg >= LEB_LAST_INDEX) || !q_byte[7];
        case (lcnt_reg)
            3'd0:    leb_acc = acc_reg | {25'b0, q_byte[6:0]};
            3'd1:    leb_acc = acc_reg | {18'b0, q_byte[6:0], 7'b0};
            3'd2:    leb_acc = acc_reg | {11'b0, q_byte[6:0], 14'b0};
            3'd3:    leb_acc = acc_reg | {4'b0, q_byte[6:0], 21'b0};
            default: leb_acc = acc_reg | {q_byte[3:0], 28'b0};
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        lcnt_next      = lcnt_reg;
        sec_left_next  = sec_left_reg;
        name_left_next = name_left_reg;
        sec_cnt_next   = sec_cnt_reg;
        sec_id_next    = sec_id_reg;
        err_next       = err_reg;
        kind           = KIND_OTHER;
        value          = '0;
        done           = 1'b0;
        sec_last       = 1'b0;

        case (phase_reg)
            PH_MAGIC:
            begin
                kind = KIND_MAGIC;
                if (!q_class.hdr_match)
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_MAGIC;
                    phase_next = PH_HALT;
                end
                else if (q_class.hdr_final)
                    phase_next = PH_VERSION;
            end
            PH_VERSION:
            begin
                kind = KIND_VERSION;
                if (!q_class.hdr_match)
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_VERSION;
                    phase_next = PH_HALT;
                end
                else if (q_class.hdr_final)
                    phase_next = PH_ID;
            end
            PH_ID:
            begin
                kind        = KIND_ID;
                sec_id_next = q_byte;
                if (sec_cnt_reg != '1)
                    sec_cnt_next = sec_cnt_reg + SCW'(1);
                acc_next   = '0;
                lcnt_next  = '0;
                phase_next = PH_SIZE;
            end
            PH_SIZE:
            begin
                kind = KIND_SIZE;
                if (leb_over)
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_OVERLONG;
                    phase_next = PH_HALT;
                end
                else if (leb_fin)
                begin
                    done          = 1'b1;
                    value         = leb_acc;
                    sec_left_next = leb_acc;
                    acc_next      = '0;
                    lcnt_next     = '0;
                    if (sec_id_reg == CUSTOM_SECTION_ID)
                        phase_next = PH_NAMELEN;
                    else if (leb_acc == '0)
                    begin
                        sec_last   = 1'b1;
                        phase_next = PH_ID;
                    end
                    else
                        phase_next = PH_CONTENT;
                end
                else
                begin
                    acc_next  = leb_acc;
                    lcnt_next = lcnt_reg + 3'd1;
                end
            end
            PH_NAMELEN:
            begin
                kind = KIND_NAMELEN;
                if (sec_left_reg == '0)
                begin
                    if (err_reg == ERR_NONE)
                        err_next = ERR_NAME;
                    phase_next = PH_HALT;
                end
                else
                begin
                    sec_left_next = sec_left_dec;
                    if (leb_over)
                    begin
                        if (err_reg == ERR_NONE)
                            err_next = ERR_OVERLONG;
                        phase_next = PH_HALT;
                    end
                    else if (leb_fin)
                    begin
                        done      = 1'b1;
                        value     = leb_acc;
                        acc_next  = '0;
                        lcnt_next = '0;
                        if (leb_acc > sec_left_dec)
                        begin
                            if (err_reg == ERR_NONE)
                                err_next = ERR_NAME;
                            phase_next = PH_HALT;
                        end
                        else
                        begin
                            name_left_next = leb_acc;
                            if (leb_acc != '0)
                                phase_next = PH_NAME;
                            else if (sec_left_dec != '0)
                                phase_next = PH_CONTENT;
                            else
                            begin
                                sec_last   = 1'b1;
                                phase_next = PH_ID;
                            end
                        end
                    end
                    else
                    begin
                        acc_next  = leb_acc;
                        lcnt_next = lcnt_reg + 3'd1;
                    end
                end
            end
            PH_NAME:
            begin
                kind           = KIND_NAME;
                name_left_next = name_left_dec;
                sec_left_next  = sec_left_dec;
                if (name_left_dec == '0)
                begin
                    if (sec_left_dec == '0)
                    begin
                        sec_last   = 1'b1;
                        phase_next = PH_ID;
                    end
                    else
                        phase_next = PH_CONTENT;
                end
            end
            PH_CONTENT:
            begin
                kind          = (sec_id_reg == CUSTOM_SECTION_ID) ? KIND_CUSTOM : KIND_OTHER;
                sec_left_next = sec_left_dec;
                if (sec_left_dec == '0)
                begin
                    sec_last   = 1'b1;
                    phase_next = PH_ID;
                end
            end
            default:
            begin
                kind = KIND_OTHER;
            end
        endcase

        if (err_next != ERR_NONE)
            sec_last = 1'b0;
        if (q_last && (err_next == ERR_NONE) && (phase_next != PH_ID))
            err_next = ERR_TRUNCATED;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
            out_valid_next = 1'b1;
        else if (results.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_MAGIC;
            acc_reg       <= '0;
            lcnt_reg      <= '0;
            sec_left_reg  <= '0;
            name_left_reg <= '0;
            sec_cnt_reg   <= '0;
            sec_id_reg    <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                if (q_last)
                begin
                    phase_reg     <= PH_MAGIC;
                    acc_reg       <= '0;
                    lcnt_reg      <= '0;
                    sec_left_reg  <= '0;
                    name_left_reg <= '0;
                    sec_cnt_reg   <= '0;
                    sec_id_reg    <= '0;
                    err_reg       <= ERR_NONE;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    acc_reg       <= acc_next;
                    lcnt_reg      <= lcnt_next;
                    sec_left_reg  <= sec_left_next;
                    name_left_reg <= name_left_next;
                    sec_cnt_reg   <= sec_cnt_next;
                    sec_id_reg    <= sec_id_next;
                    err_reg       <= err_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_kind_reg    <= kind;
            out_byte_reg    <= q_byte;
            out_offset_reg  <= off32;
            out_secnum_reg  <= secnum16;
            out_secid_reg   <= sec_id_next;
            out_value_reg   <= done ? value : 32'd0;
            out_done_reg    <= done;
            out_seclast_reg <= sec_last;
            out_err_reg     <= err_next;
            out_last_reg    <= q_last;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.byte_kind      = out_kind_reg;
    assign results.byte_echo      = out_byte_reg;
    assign results.file_offset    = out_offset_reg;
    assign results.section_number = out_secnum_reg;
    assign results.section_kind   = out_secid_reg;
    assign results.decoded_value  = out_value_reg;
    assign results.value_done     = out_done_reg;
    assign results.section_last   = out_seclast_reg;
    assign results.error_code     = out_err_reg;
    assign results.end_echo       = out_last_reg;

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |-> (phase_reg == PH_HALT))
        else $error("sticky error without halted parse");

    a_done_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_done_reg) |->
            (out_kind_reg == KIND_SIZE || out_kind_reg == KIND_NAMELEN))
        else $error("value_done on a byte that is not a LEB byte");

    a_seclast_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_seclast_reg) |-> (out_err_reg == ERR_NONE))
        else $error("section end flagged under an error");

    a_leb_count: assert property (@(posedge clk) disable iff (!rst_n)
        (lcnt_reg <= LEB_LAST_INDEX))
        else $error("LEB byte count out of range");

endmodule

/* sim/wasm_section_parser_tb.sv */
// Self-checking testbench for wasm_section_parser: directed and random WebAssembly files against a predictor.
module wasm_section_parser_tb
    import wsp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 4000;
    localparam int ITEMS_PER_PHASE = 700;
    localparam int DRAIN_CYCLES = 8;

    localparam logic [7:0] MAGIC_SEQ [4] = '{8'h00, 8'h61, 8'h73, 8'h6D};
    localparam logic [7:0] VERSION_SEQ [4] = '{8'h01, 8'h00, 8'h00, 8'h00};

    typedef enum logic [2:0] {
        PH_MAGIC, PH_VERSION, PH_ID, PH_SIZE, PH_NAMELEN, PH_NAME, PH_CONTENT, PH_HALT
    } parse_phase_t;

    typedef struct packed {
        wsp_kind_t   kind;
        logic [7:0]  echo;
        logic [31:0] offset;
        logic [15:0] sec_num;
        logic [7:0]  sec_id;
        logic [31:0] value;
        logic        done;
        logic        sec_last;
        wsp_err_t    err;
        logic        end_flag;
    } byte_result_t;

    class parse_scoreboard;
        parse_phase_t phase;
        int           hdr_pos;
        logic [31:0]  acc;
        int           leb_cnt;
        logic [31:0]  sec_left;
        logic [31:0]  name_left;
        logic [31:0]  offset;
        logic [15:0]  sec_count;
        logic [7:0]   sec_id;
        wsp_err_t     err;
        byte_result_t pending[$];
        int           mismatches;

        function new();
            mismatches = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase = PH_MAGIC;
            hdr_pos = 0;
            acc = '0;
            leb_cnt = 0;
            sec_left = '0;
            name_left = '0;
            offset = '0;
            sec_count = '0;
            sec_id = '0;
            err = ERR_NONE;
        endfunction

        function void flag(wsp_err_t code);
            if (err == ERR_NONE)
                err = code;
            phase = PH_HALT;
        endfunction

        // 1: value complete, 0: more bytes follow, -1: overlong
        function int leb_step(logic [7:0] b);
            if (leb_cnt >= 4)
            begin
                if (b[7] || (b[6:4] != 3'b000))
                    return -1;
                acc[31:28] = acc[31:28] | b[3:0];
                return 1;
            end
            acc = acc | (32'(b[6:0]) << (7 * leb_cnt));
            leb_cnt = leb_cnt + 1;
            return b[7] ? 0 : 1;
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            byte_result_t p;
            logic [31:0]  value;
            logic         done;
            logic         sl;
            int           r;
            p.kind = KIND_OTHER;
            p.offset = offset;
            value = '0;
            done = 1'b0;
            sl = 1'b0;
            case (phase)
                PH_MAGIC:
                begin
                    p.kind = KIND_MAGIC;
                    if (b != MAGIC_SEQ[hdr_pos])
                        flag(ERR_MAGIC);
                    else if (hdr_pos >= 3)
                    begin
                        hdr_pos = 0;
                        phase = PH_VERSION;
                    end
                    else
                        hdr_pos++;
                end
                PH_VERSION:
                begin
                    p.kind = KIND_VERSION;
                    if (b != VERSION_SEQ[hdr_pos])
                        flag(ERR_VERSION);
                    else if (hdr_pos >= 3)
                    begin
                        hdr_pos = 0;
                        phase = PH_ID;
                    end
                    else
                        hdr_pos++;
                end
                PH_ID:
                begin
                    p.kind = KIND_ID;
                    sec_id = b;
                    if (sec_count != 16'hFFFF)
                        sec_count++;
                    acc = '0;
                    leb_cnt = 0;
                    phase = PH_SIZE;
                end
                PH_SIZE:
                begin
                    p.kind = KIND_SIZE;
                    r = leb_step(b);
                    if (r < 0)
                        flag(ERR_OVERLONG);
                    else if (r > 0)
                    begin
                        done = 1'b1;
                        value = acc;
                        sec_left = acc;
                        acc = '0;
                        leb_cnt = 0;
                        if (sec_id == CUSTOM_SECTION_ID)
                            phase = PH_NAMELEN;
                        else if (sec_left == 0)
                        begin
                            sl = 1'b1;
                            phase = PH_ID;
                        end
                        else
                            phase = PH_CONTENT;
                    end
                end
                PH_NAMELEN:
                begin
                    p.kind = KIND_NAMELEN;
                    if (sec_left == 0)
                        flag(ERR_NAME);
                    else
                    begin
                        sec_left--;
                        r = leb_step(b);
                        if (r < 0)
                            flag(ERR_OVERLONG);
                        else if (r > 0)
                        begin
                            done = 1'b1;
                            value = acc;
                            acc = '0;
                            leb_cnt = 0;
                            if (value > sec_left)
                                flag(ERR_NAME);
                            else
                            begin
                                name_left = value;
                                if (name_left != 0)
                                    phase = PH_NAME;
                                else if (sec_left != 0)
                                    phase = PH_CONTENT;
                                else
                                begin
                                    sl = 1'b1;
                                    phase = PH_ID;
                                end
                            end
                        end
                    end
                end
                PH_NAME:
                begin
                    p.kind = KIND_NAME;
                    name_left--;
                    sec_left--;
                    if (name_left == 0)
                    begin
                        if (sec_left == 0)
                        begin
                            sl = 1'b1;
                            phase = PH_ID;
                        end
                        else
                            phase = PH_CONTENT;
                    end
                end
                PH_CONTENT:
                begin
                    p.kind = (sec_id == CUSTOM_SECTION_ID) ? KIND_CUSTOM : KIND_OTHER;
                    sec_left--;
                    if (sec_left == 0)
                    begin
                        sl = 1'b1;
                        phase = PH_ID;
                    end
                end
                default:
                    p.kind = KIND_OTHER;
            endcase
            if (err != ERR_NONE)
                sl = 1'b0;
            if (l && err == ERR_NONE && phase != PH_ID)
                err = ERR_TRUNCATED;
            p.echo = b;
            p.sec_num = sec_count;
            p.sec_id = sec_id;
            p.value = done ? value : 32'd0;
            p.done = done;
            p.sec_last = sl;
            p.err = err;
            p.end_flag = l;
            pending.push_back(p);
            offset = offset + 1;
            if (l)
                clear_state();
        endfunction

        function string fmt(byte_result_t r);
            return $sformatf({"kind=%0d echo=%02h off=%0d sec=%0d id=%02h val=%08h ",
                              "done=%0b slast=%0b err=%0d end=%0b"},
                             r.kind, r.echo, r.offset, r.sec_num, r.sec_id, r.value,
                             r.done, r.sec_last, r.err, r.end_flag);
        endfunction

        function void check_result(byte_result_t o);
            byte_result_t p;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected transaction: %s", $realtime, fmt(o));
                return;
            end
            p = pending.pop_front();
            if (p.kind !== o.kind || p.echo !== o.echo || p.offset !== o.offset ||
                p.sec_num !== o.sec_num || p.sec_id !== o.sec_id || p.value !== o.value ||
                p.done !== o.done || p.sec_last !== o.sec_last || p.err !== o.err ||
                p.end_flag !== o.end_flag)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] mismatch", $realtime);
                    $display("    expected: %s", fmt(p));
                    $display("    actual:   %s", fmt(o));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    wsp_in_if  bytes_if();
    wsp_out_if results_if();

    wasm_section_parser uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes_if),
        .results (results_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    parse_scoreboard sb;
    logic [7:0]      file_bytes[$];
    int              src_idle_pct;
    int              snk_idle_pct;
    int              bytes_sent;
    int              stall_cycles;

    function automatic int leb_min_len(logic [31:0] v);
        int n;
        n = 1;
        while (n < 5 && (v >> (7 * n)) != 0)
            n++;
        return n;
    endfunction

    // sometimes a non-minimal (padded) encoding
    function automatic int leb_pick_len(logic [31:0] v);
        int n;
        n = leb_min_len(v);
        if ($urandom_range(3) == 0)
            n = $urandom_range(n, 5);
        return n;
    endfunction

    function automatic void push_leb(logic [31:0] v, int len);
        logic [7:0] bt;
        int         i;
        for (i = 0; i < len; i++)
        begin
            if (i == 4)
                bt = {4'b0000, v[31:28]};
            else
                bt = 8'((v >> (7 * i)) & 32'h7F);
            if (i < len - 1)
                bt[7] = 1'b1;
            file_bytes.push_back(bt);
        end
    endfunction

    function automatic void push_random(int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_header();
        int i;
        for (i = 0; i < 4; i++)
            file_bytes.push_back(MAGIC_SEQ[i]);
        for (i = 0; i < 4; i++)
            file_bytes.push_back(VERSION_SEQ[i]);
    endfunction

    function automatic void add_section();
        logic [31:0] nl;
        logic [31:0] sz;
        int          k;
        int          c;
        if ($urandom_range(2) == 0)
        begin
            nl = $urandom_range(0, 6);
            c = $urandom_range(0, 6);
            k = leb_pick_len(nl);
            sz = k + nl + c;
            file_bytes.push_back(CUSTOM_SECTION_ID);
            push_leb(sz, leb_pick_len(sz));
            push_leb(nl, k);
            push_random(nl + c);
        end
        else
        begin
            sz = $urandom_range(0, 12);
            file_bytes.push_back(8'($urandom_range(1, 255)));
            push_leb(sz, leb_pick_len(sz));
            push_random(sz);
        end
    endfunction

    function automatic void make_random_file();
        int          sel;
        int          cut;
        int          i;
        logic [31:0] v;
        logic [31:0] sz;
        logic [7:0]  b;
        file_bytes.delete();
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            if ($urandom_range(1) == 0)
                file_bytes.push_back(8'h00);
            push_random($urandom_range(1, 10));
            return;
        end
        push_header();
        repeat ($urandom_range(0, 4)) add_section();
        sel = $urandom_range(99);
        if (sel < 10)
        begin
            i = $urandom_range(0, file_bytes.size() - 1);
            file_bytes[i] = file_bytes[i] ^ 8'($urandom_range(1, 255));
        end
        else if (sel < 20)
        begin
            cut = $urandom_range(1, file_bytes.size() - 1);
            while (file_bytes.size() > cut)
                void'(file_bytes.pop_back());
        end
        else if (sel < 28)
        begin
            // overlong LEB, in the size or in a custom name length
            if ($urandom_range(1) == 0)
                file_bytes.push_back(8'($urandom_range(1, 255)));
            else
            begin
                file_bytes.push_back(CUSTOM_SECTION_ID);
                push_leb(32'd20, 1);
            end
            repeat (4) file_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            do
                b = 8'($urandom);
            while (!(b[7] || b[6:4] != 3'b000));
            file_bytes.push_back(b);
            push_random($urandom_range(0, 3));
        end
        else if (sel < 35)
        begin
            // name length beyond the section
            sz = $urandom_range(0, 6);
            file_bytes.push_back(CUSTOM_SECTION_ID);
            push_leb(sz, leb_min_len(sz));
            v = ($urandom_range(1) == 0) ? sz : $urandom;
            push_leb(v, leb_min_len(v));
            push_random($urandom_range(0, 3));
        end
        else if (sel < 42)
        begin
            // huge size, file cut short
            file_bytes.push_back(8'($urandom));
            v = $urandom;
            push_leb(v, leb_min_len(v));
            push_random($urandom_range(0, 3));
        end
        else if (sel < 46)
        begin
            file_bytes.push_back(CUSTOM_SECTION_ID);
            file_bytes.push_back(8'h00);
            push_random($urandom_range(0, 1));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic l);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            bytes_if.valid <= 1'b0;
            @(negedge clk);
        end
        bytes_if.valid <= 1'b1;
        bytes_if.data_byte <= b;
        bytes_if.file_last <= l;
        @(posedge clk);
        while (!bytes_if.ready)
            @(posedge clk);
        sb.note_byte(b, l);
        bytes_sent++;
    endtask

    task automatic send_file();
        int i;
        for (i = 0; i < file_bytes.size(); i++)
            send_byte(file_bytes[i], i == file_bytes.size() - 1);
    endtask

    always @(negedge clk)
        results_if.ready <= ($urandom_range(99) >= snk_idle_pct);

    always @(posedge clk)
    begin
        byte_result_t o;
        if (rst_n && results_if.valid && results_if.ready)
        begin
            o.kind = wsp_kind_t'(results_if.byte_kind);
            o.echo = results_if.byte_echo;
            o.offset = results_if.file_offset;
            o.sec_num = results_if.section_number;
            o.sec_id = results_if.section_kind;
            o.value = results_if.decoded_value;
            o.done = results_if.value_done;
            o.sec_last = results_if.section_last;
            o.err = wsp_err_t'(results_if.error_code);
            o.end_flag = results_if.end_echo;
            sb.check_result(o);
        end
    end

    always @(posedge clk)
    begin
        if ((bytes_if.valid && bytes_if.ready) || (results_if.valid && results_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** wasm_section_parser: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int ph;
        sb = new();
        stall_cycles = 0;
        bytes_sent = 0;
        src_idle_pct = 35;
        snk_idle_pct = 63;
        rst_n = 1'b0;
        bytes_if.valid = 1'b0;
        bytes_if.data_byte = 8'h00;
        bytes_if.file_last = 1'b0;
        results_if.ready = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // well-formed file: custom section with name, empty section, plain section
        file_bytes.delete();
        push_header();
        file_bytes.push_back(CUSTOM_SECTION_ID);
        push_leb(32'd3, 1);
        push_leb(32'd1, 1);
        file_bytes.push_back(8'h78);
        file_bytes.push_back(8'hAA);
        file_bytes.push_back(8'h01);
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h0B);
        push_leb(32'd2, 1);
        file_bytes.push_back(8'hFF);
        file_bytes.push_back(8'h80);
        send_file();
        // bad magic on a one-byte file, then a sticky bad magic
        file_bytes.delete();
        file_bytes.push_back(8'h6D);
        send_file();
        file_bytes.delete();
        file_bytes.push_back(8'h00);
        file_bytes.push_back(8'h62);
        file_bytes.push_back(8'h73);
        send_file();

        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 35;
                    snk_idle_pct = 63;
                end
                1:
                begin
                    src_idle_pct = 63;
                    snk_idle_pct = 35;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            while (bytes_sent < ITEMS_PER_PHASE * (ph + 1))
            begin
                make_random_file();
                send_file();
            end
        end
        @(negedge clk);
        bytes_if.valid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("** wasm_section_parser: PASSED **");
        else
            $display("** wasm_section_parser: FAILED **");
        $finish;
    end

endmodule

/* filelist.f */
rtl/wsp_pkg.sv
rtl/wsp_in_if.sv
rtl/wsp_out_if.sv
rtl/wsp_front.sv
rtl/wsp_queue.sv
rtl/wsp_back.sv
rtl/wasm_section_parser.sv
sim/wasm_section_parser_tb.sv
